// ===== design/assert_macros.svh =====
// Assertion macros shared by the decoder's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is switched off while reset is high.
`define HTFD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that must also hold during reset.
`define HTFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/htfd_pkg.sv =====
// Types, constants and the CRC-8 function of the humidity/temperature frame decoder.
package htfd_pkg;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       measure_kind;
  } in_t;

  typedef struct packed {
    logic signed [11:0] scaled_value;
    logic [15:0]        raw_reading;
    logic               crc_ok;
    logic               kind_out;
  } out_t;

  // Assembled frame handed from the byte collector to the converter.
  typedef struct packed {
    logic [15:0] raw;
    logic        crc_ok;
    logic        kind;
  } frame_t;

  localparam logic [7:0]  CRC_POLY    = 8'h31;     // x^8 term is implied
  localparam logic [7:0]  CRC_INIT    = 8'h00;
  localparam logic [15:0] STATUS_MASK = 16'hFFFC;

  // Both conversions share the divisor 655360 = 10 * 65536. Humidity is
  // scaled by ten in the numerator so that one datapath serves both.
  localparam logic [14:0] TEMP_GAIN = 15'd17572;
  localparam logic [14:0] HUM_GAIN  = 15'd12500;
  localparam logic signed [31:0] TEMP_OFFSET = 32'sd307036160;
  localparam logic signed [31:0] HUM_OFFSET  = 32'sd39321600;

  // Exact division by ten for dividends below 2^15.
  localparam logic [15:0] DIV10_RECIP = 16'd52429;
  localparam int unsigned DIV10_SHIFT = 19;

  localparam logic KIND_TEMP = 1'b0;
  localparam logic KIND_HUM  = 1'b1;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== design/htfd_frame.sv =====
// Byte collector: gathers the three frame bytes and checks the CRC-8.
`include "assert_macros.svh"

module htfd_frame (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  htfd_pkg::in_t   in_data,
  output logic            frame_valid,
  input  logic            frame_ready,
  output htfd_pkg::frame_t frame
);
  import htfd_pkg::*;

  typedef enum logic [1:0] {
    POS_HIGH = 2'd0,
    POS_LOW  = 2'd1,
    POS_CRC  = 2'd2
  } pos_t;

  pos_t       pos;
  logic [7:0] crc;
  logic [7:0] data_high;
  logic [7:0] data_low;
  logic       in_acc;

  assign in_ready = !frame_valid || frame_ready;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= POS_HIGH;
      crc         <= CRC_INIT;
      data_high   <= 8'h00;
      data_low    <= 8'h00;
      frame_valid <= 1'b0;
    end else begin
      if (frame_valid && frame_ready) begin
        frame_valid <= 1'b0;
      end
      if (in_acc) begin
        unique case (pos)
          POS_HIGH: begin
            data_high <= in_data.rx_byte;
            crc       <= crc8_byte(CRC_INIT, in_data.rx_byte);
            pos       <= POS_LOW;
          end
          POS_LOW: begin
            data_low <= in_data.rx_byte;
            crc      <= crc8_byte(crc, in_data.rx_byte);
            pos      <= POS_CRC;
          end
          default: begin
            // The CRC byte closes the frame; an unused position acts the same.
            frame.raw    <= {data_high, data_low} & STATUS_MASK;
            frame.crc_ok <= (crc == in_data.rx_byte);
            frame.kind   <= in_data.measure_kind;
            frame_valid  <= 1'b1;
            pos          <= POS_HIGH;
            crc          <= CRC_INIT;
          end
        endcase
      end
    end
  end

  `HTFD_ASSERT(a_frame_close, clk, rst,
    in_acc && pos == POS_CRC |=> frame_valid && pos == POS_HIGH && crc == CRC_INIT,
    "frame did not close after the CRC byte")
  `HTFD_ASSERT(a_high_to_low, clk, rst,
    in_acc && pos == POS_HIGH |=> pos == POS_LOW,
    "position did not advance after the high byte")
  `HTFD_ASSERT(a_frame_hold, clk, rst,
    frame_valid && !frame_ready |=> frame_valid && $stable(frame),
    "stalled frame was lost or changed")

endmodule

// ===== design/htfd_convert.sv =====
// Converter pipeline: raw reading to temperature or humidity times ten.
`include "assert_macros.svh"

module htfd_convert (
  input  logic             clk,
  input  logic             rst,
  input  logic             frame_valid,
  output logic             frame_ready,
  input  htfd_pkg::frame_t frame,
  output logic             out_valid,
  input  logic             out_ready,
  output htfd_pkg::out_t   out_data
);
  import htfd_pkg::*;

  // Numerator stage.
  logic               n_v;
  frame_t             n_frame;
  logic signed [31:0] num;
  logic [30:0]        prod;
  logic [14:0]        gain;
  logic signed [31:0] offset;

  // Magnitude stage.
  logic               q_v;
  frame_t             q_frame;
  logic               q_neg;
  logic [14:0]        q1;
  logic [31:0]        mag;

  // Output stage.
  logic [30:0]        prod10;
  logic [11:0]        quot;

  logic o_ok, q_ok, n_ok;

  assign o_ok        = !out_valid || out_ready;
  assign q_ok        = !q_v || o_ok;
  assign n_ok        = !n_v || q_ok;
  assign frame_ready = n_ok;

  assign gain   = (frame.kind == KIND_HUM) ? HUM_GAIN : TEMP_GAIN;
  assign offset = (frame.kind == KIND_HUM) ? HUM_OFFSET : TEMP_OFFSET;
  assign prod   = frame.raw * gain;

  assign mag = num[31] ? 32'(-num) : 32'(num);

  assign prod10 = q1 * DIV10_RECIP;
  assign quot   = prod10[30:DIV10_SHIFT];

  always_ff @(posedge clk) begin
    if (rst) begin
      n_v       <= 1'b0;
      q_v       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (n_ok) begin
        n_v <= frame_valid;
        if (frame_valid) begin
          n_frame <= frame;
          num     <= $signed({1'b0, prod}) - offset;
        end
      end
      if (q_ok) begin
        q_v <= n_v;
        if (n_v) begin
          q_frame <= n_frame;
          q_neg   <= num[31];
          // Dividing the magnitude keeps the quotient truncated toward zero.
          q1      <= mag[30:16];
        end
      end
      if (o_ok) begin
        out_valid <= q_v;
        if (q_v) begin
          out_data.scaled_value <= q_neg ? $signed(12'(12'd0 - quot))
                                         : $signed(quot);
          out_data.raw_reading  <= q_frame.raw;
          out_data.crc_ok       <= q_frame.crc_ok;
          out_data.kind_out     <= q_frame.kind;
        end
      end
    end
  end

  `HTFD_ASSERT(a_num_hold, clk, rst,
    n_v && !q_ok |=> n_v && $stable(num) && $stable(n_frame),
    "stalled numerator was lost or changed")
  `HTFD_ASSERT(a_range, clk, rst,
    out_valid |-> out_data.scaled_value >= -12'sd468 && out_data.scaled_value <= 12'sd1288,
    "converted value out of range")
  `HTFD_ASSERT(a_hum_floor, clk, rst,
    out_valid && out_data.kind_out == KIND_HUM |-> out_data.scaled_value >= -12'sd60,
    "humidity value below its floor")

endmodule

// ===== design/humidity_temp_frame_decoder.sv =====
// Top level of the humidity/temperature sensor frame decoder.
// Accepts one response byte per cycle while in_ready is high (data high, data
// low, CRC) and, on every third byte, produces one result: the reading with
// its status bits cleared, a CRC-8 (polynomial 0x31, initial value 0) match
// flag, and the value converted to temperature or relative humidity times
// ten, truncated toward zero. A result is produced even when the CRC does not
// match. The input request rate is one byte per cycle unless in_ready is low;
// after its CRC byte is taken, a result passes the frame register, the
// numerator multiplier, the magnitude stage and the divide-by-ten multiplier,
// and every stage holds its contents while the output side stalls.
module humidity_temp_frame_decoder (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  htfd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output htfd_pkg::out_t out_data
);
  import htfd_pkg::*;

  logic   frame_valid;
  logic   frame_ready;
  frame_t frame;

  htfd_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame)
  );

  htfd_convert u_convert (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

// ===== sim/humidity_temp_frame_decoder_tb.sv =====
// Self-checking testbench for the humidity/temperature sensor frame decoder.
`timescale 1ns / 1ps

import htfd_pkg::*;

class frame_scoreboard;
  int unsigned failures;
  out_t        expected_q[$];
  logic [1:0]  position;
  logic [7:0]  crc_acc;
  logic [7:0]  hi_byte;
  logic [7:0]  lo_byte;

  function new();
    failures = 0;
    position = 2'd0;
    crc_acc  = 8'h00;
    hi_byte  = 8'h00;
    lo_byte  = 8'h00;
  endfunction

  // CRC-8 step with the full nine-bit polynomial x^8+x^5+x^4+1.
  function logic [7:0] crc_step(input logic [7:0] acc, input logic [7:0] data);
    logic [8:0] r;
    r = {1'b0, acc ^ data};
    for (int i = 0; i < 8; i++) begin
      r = r << 1;
      if (r[8]) begin
        r = r ^ 9'h131;
      end
    end
    return r[7:0];
  endfunction

  // Signed 64-bit division truncates toward zero, matching the conversion.
  function logic signed [11:0] scale_reading(input logic [15:0] raw, input logic kind);
    longint r;
    longint v;
    r = longint'(raw);
    if (kind == KIND_HUM) begin
      v = (1250 * r - 60 * 65536) / 65536;
    end else begin
      v = (17572 * r - 4685 * 65536) / 655360;
    end
    return v[11:0];
  endfunction

  function void note_request(input in_t req);
    out_t res;
    if (position == 2'd0) begin
      hi_byte  = req.rx_byte;
      crc_acc  = crc_step(8'h00, req.rx_byte);
      position = 2'd1;
    end else if (position == 2'd1) begin
      lo_byte  = req.rx_byte;
      crc_acc  = crc_step(crc_acc, req.rx_byte);
      position = 2'd2;
    end else begin
      res.raw_reading  = {hi_byte, lo_byte} & 16'hFFFC;
      res.scaled_value = scale_reading(res.raw_reading, req.measure_kind);
      res.crc_ok       = (crc_acc == req.rx_byte);
      res.kind_out     = req.measure_kind;
      expected_q.push_back(res);
      position = 2'd0;
      crc_acc  = 8'h00;
    end
  endfunction

  function void check_result(input out_t got);
    out_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual raw %h", $time,
               got.raw_reading);
      failures++;
      return;
    end
    want = expected_q.pop_front();
    if (got.scaled_value !== want.scaled_value) begin
      $display("%0t: scaled_value expected %0d actual %0d", $time,
               want.scaled_value, got.scaled_value);
      failures++;
    end
    if (got.raw_reading !== want.raw_reading) begin
      $display("%0t: raw_reading expected %h actual %h", $time,
               want.raw_reading, got.raw_reading);
      failures++;
    end
    if (got.crc_ok !== want.crc_ok) begin
      $display("%0t: crc_ok expected %b actual %b", $time, want.crc_ok, got.crc_ok);
      failures++;
    end
    if (got.kind_out !== want.kind_out) begin
      $display("%0t: kind_out expected %b actual %b", $time, want.kind_out, got.kind_out);
      failures++;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module humidity_temp_frame_decoder_tb;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  frame_scoreboard sb = new();

  humidity_temp_frame_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_result(out_data);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance with
  // valid still high, so a following request does not toggle it in one step.
  task automatic send_byte(input logic [7:0] b, input logic kind);
    in_t req;
    req.rx_byte      = b;
    req.measure_kind = kind;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do begin
      @(posedge clk);
    end while (!in_ready);
    sb.note_request(req);
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [7:0] hi, input logic [7:0] lo,
                            input logic [7:0] crc_flip, input logic [2:0] kinds);
    logic [7:0] crc;
    crc = sb.crc_step(sb.crc_step(8'h00, hi), lo) ^ crc_flip;
    send_byte(hi, kinds[2]);
    send_byte(lo, kinds[1]);
    send_byte(crc, kinds[0]);
  endtask

  task automatic send_random_frames(input int count);
    logic [7:0] flip;
    for (int i = 0; i < count; i++) begin
      flip = 8'h00;
      if ($urandom_range(99) < 15) begin
        flip = 8'($urandom_range(255));
      end
      send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), flip,
                 3'($urandom_range(7)));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Extremes of the reading for both kinds, then failing CRCs, then the
    // kind changing within a frame (only the CRC byte's kind counts).
    send_frame(8'h00, 8'h00, 8'h00, {3{KIND_TEMP}});
    send_frame(8'h00, 8'h00, 8'h00, {3{KIND_HUM}});
    send_frame(8'hFF, 8'hFF, 8'h00, {3{KIND_TEMP}});
    send_frame(8'hFF, 8'hFF, 8'h00, {3{KIND_HUM}});
    send_frame(8'h80, 8'h01, 8'hFF, {3{KIND_TEMP}});
    send_frame(8'h12, 8'h34, 8'h01, {3{KIND_HUM}});
    send_frame(8'h66, 8'h5C, 8'h00, {KIND_HUM, KIND_HUM, KIND_TEMP});
    send_frame(8'h7F, 8'hFE, 8'h00, {KIND_TEMP, KIND_TEMP, KIND_HUM});

    send_random_frames(66);
    send_idle_pct = 80;
    send_random_frames(66);
    send_idle_pct = 0;
    recv_stall_pct = 80;
    send_random_frames(66);
    send_idle_pct = 15;
    recv_stall_pct = 15;
    send_random_frames(66);

    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    if (sb.failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+design
design/htfd_pkg.sv
design/htfd_frame.sv
design/htfd_convert.sv
design/humidity_temp_frame_decoder.sv
sim/humidity_temp_frame_decoder_tb.sv
